// ----- design/fcta_pkg.sv -----
// Package for the floor and ceiling texel addresser: widths, codes, command
// and status structs, word layouts and the texel index function.
// No dependencies; every other design file imports it.
package fcta_pkg;

  localparam int FRAC_BITS    = 16;  // fraction bits of world coordinates
  localparam int MAX_TEX_LOG2 = 8;
  localparam int ACC_W        = 48;
  localparam int POS_W        = 32;
  localparam int VEC_W        = 16;
  localparam int ROW_W        = 12;
  localparam int CFG_W        = 13;
  localparam int MODE_W       = 2;
  localparam int LOG2_W       = 4;
  localparam int TEX_W        = 16;
  localparam int DIST_W       = 28;
  localparam int OP_W         = VEC_W + 1;
  localparam int PROD_W       = DIST_W + OP_W;     // signed product width
  localparam int DIV_W        = PROD_W - 1;        // magnitude width
  localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int DIR_SHIFT    = 14;                // Q1.14 direction scale
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT,
    CFG_FLOOR_MODE,
    CFG_CEILING_MODE,
    CFG_FLOOR_LOG2_W,
    CFG_FLOOR_LOG2_H,
    CFG_CEIL_LOG2_W,
    CFG_CEIL_LOG2_H
  } cfg_idx_t;

  localparam logic CMD_ROW_START = 1'b0;
  localparam logic CMD_PIXEL     = 1'b1;

  localparam logic [MODE_W-1:0] MODE_TEXTURED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID    = 2'd1;

  typedef enum logic {DIV_SRC_DIST, DIV_SRC_PROD} div_src_t;

  typedef enum logic [1:0] {
    MUL_STEP_X,
    MUL_STEP_Y,
    MUL_START_X,
    MUL_START_Y
  } mul_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST_GO,
    ST_DIST_WAIT,
    ST_SX_MUL,
    ST_SX_GO,
    ST_SX_WAIT,
    ST_SY_MUL,
    ST_SY_GO,
    ST_SY_WAIT,
    ST_X0_MUL,
    ST_X0_LOAD,
    ST_Y0_MUL,
    ST_Y0_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic                    row_load;
    logic                    pix_step;
    logic                    div_start;
    div_src_t                div_src;
    logic                    dist_load;
    mul_src_t                mul_src;
    logic                    prod_load;
    logic                    step_x_load;
    logic                    step_y_load;
    logic                    acc_x_load;
    logic                    acc_y_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } ctrl_status_t;

  typedef struct packed {
    logic                    cmd;
    logic [ROW_W-1:0]        screen_row;
    logic signed [POS_W-1:0] cam_pos_x;
    logic signed [POS_W-1:0] cam_pos_y;
    logic signed [VEC_W-1:0] view_dir_x;
    logic signed [VEC_W-1:0] view_dir_y;
    logic signed [VEC_W-1:0] view_plane_x;
    logic signed [VEC_W-1:0] view_plane_y;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] pixel_column;
    logic [ROW_W-1:0] floor_row_out;
    logic [ROW_W-1:0] ceiling_row_out;
    logic [TEX_W-1:0] floor_texel;
    logic [TEX_W-1:0] ceiling_texel;
    logic             floor_write;
    logic             floor_solid;
    logic             ceiling_write;
    logic             ceiling_solid;
    logic             row_last;
  } out_item_t;

  // Texel index from the fraction bits of the two world coordinates.
  function automatic logic [TEX_W-1:0] texel_index(
    input logic [FRAC_BITS-1:0] fx,
    input logic [FRAC_BITS-1:0] fy,
    input logic [LOG2_W-1:0]    lw_raw,
    input logic [LOG2_W-1:0]    lh_raw
  );
    logic [LOG2_W-1:0]    lw;
    logic [LOG2_W-1:0]    lh;
    logic [FRAC_BITS-1:0] tx;
    logic [FRAC_BITS-1:0] ty;
    lw = (lw_raw > LOG2_W'(MAX_TEX_LOG2)) ? LOG2_W'(MAX_TEX_LOG2) : lw_raw;
    lh = (lh_raw > LOG2_W'(MAX_TEX_LOG2)) ? LOG2_W'(MAX_TEX_LOG2) : lh_raw;
    tx = fx >> (5'(FRAC_BITS) - {1'b0, lw});
    ty = fy >> (5'(FRAC_BITS) - {1'b0, lh});
    return TEX_W'(ty << lw) | TEX_W'(tx);
  endfunction

endpackage

// ----- design/fcta_ifs.sv -----
// Valid/ready channel interfaces for the texel addresser's input and result words.
// Depends on fcta_pkg for the field widths.
interface fcta_in_if import fcta_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [ROW_W-1:0]        screen_row;
  logic signed [POS_W-1:0] cam_pos_x;
  logic signed [POS_W-1:0] cam_pos_y;
  logic signed [VEC_W-1:0] view_dir_x;
  logic signed [VEC_W-1:0] view_dir_y;
  logic signed [VEC_W-1:0] view_plane_x;
  logic signed [VEC_W-1:0] view_plane_y;

  modport source (output valid, cmd, screen_row, cam_pos_x, cam_pos_y,
                  view_dir_x, view_dir_y, view_plane_x, view_plane_y,
                  input ready);
  modport sink (input valid, cmd, screen_row, cam_pos_x, cam_pos_y,
                view_dir_x, view_dir_y, view_plane_x, view_plane_y,
                output ready);
endinterface

interface fcta_out_if import fcta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] pixel_column;
  logic [ROW_W-1:0] floor_row_out;
  logic [ROW_W-1:0] ceiling_row_out;
  logic [TEX_W-1:0] floor_texel;
  logic [TEX_W-1:0] ceiling_texel;
  logic             floor_write;
  logic             floor_solid;
  logic             ceiling_write;
  logic             ceiling_solid;
  logic             row_last;

  modport source (output valid, pixel_column, floor_row_out, ceiling_row_out,
                  floor_texel, ceiling_texel, floor_write, floor_solid,
                  ceiling_write, ceiling_solid, row_last,
                  input ready);
  modport sink (input valid, pixel_column, floor_row_out, ceiling_row_out,
                floor_texel, ceiling_texel, floor_write, floor_solid,
                ceiling_write, ceiling_solid, row_last,
                output ready);
endinterface

// ----- design/fcta_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fcta_pkg for its widths.
module fcta_div import fcta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CFG_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W-1:0]     quot_r, quot_nxt;
  logic [CFG_W-1:0]     rem_r, rem_nxt;
  logic [CFG_W-1:0]     dsr_r, dsr_nxt;
  logic [CFG_W:0]       shifted;
  logic [CFG_W:0]       trial;

  assign shifted = {rem_r, quot_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      run_nxt  = 1'b1;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (run_r) begin
      // The remainder stays below the divisor, so the low bits hold it.
      if (!trial[CFG_W]) begin
        rem_nxt = trial[CFG_W-1:0];
      end else begin
        rem_nxt = shifted[CFG_W-1:0];
      end
      quot_nxt = {quot_r[DIV_W-2:0], ~trial[CFG_W]};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// ----- design/fcta_dp.sv -----
// Datapath: configuration registers, row setup arithmetic, world accumulators
// and the result word register. Depends on fcta_pkg and fcta_div.
module fcta_dp import fcta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  in_item_t             in_item,
  input  ctrl_cmd_t            cmd,
  output ctrl_status_t         status,
  output out_item_t            out_item
);

  // Configuration registers.
  logic [CFG_W-1:0]  width_r, height_r;
  logic [MODE_W-1:0] fmode_r, cmode_r;
  logic [LOG2_W-1:0] flw_r, flh_r, clw_r, clh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(640);
      height_r <= CFG_W'(480);
      fmode_r  <= MODE_TEXTURED;
      cmode_r  <= MODE_TEXTURED;
      flw_r    <= LOG2_W'(6);
      flh_r    <= LOG2_W'(6);
      clw_r    <= LOG2_W'(6);
      clh_r    <= LOG2_W'(6);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        CFG_FLOOR_MODE:    fmode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_CEILING_MODE:  cmode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_FLOOR_LOG2_W:  flw_r    <= cfg_wdata[LOG2_W-1:0];
        CFG_FLOOR_LOG2_H:  flh_r    <= cfg_wdata[LOG2_W-1:0];
        CFG_CEIL_LOG2_W:   clw_r    <= cfg_wdata[LOG2_W-1:0];
        CFG_CEIL_LOG2_H:   clh_r    <= cfg_wdata[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Row state and world accumulators.
  logic [ROW_W-1:0]         row_r, col_r;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r, step_x_r, step_y_r;
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r;
  logic signed [VEC_W-1:0]  dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [DIST_W-1:0]        dist_r;
  logic signed [PROD_W-1:0] prod_r;
  out_item_t                out_r;

  // Row offset below the horizon, clamped to at least one.
  logic signed [ROW_W+1:0] off_s;
  logic [CFG_W-1:0]        off_div;
  logic [CFG_W-1:0]        w_div;
  logic [DIV_W-1:0]        div_dividend;
  logic [CFG_W-1:0]        div_divisor;
  logic [DIV_W-1:0]        div_quot;
  logic                    div_done;
  logic [PROD_W-1:0]       prod_mag;

  assign off_s   = $signed({2'b00, row_r}) - $signed({2'b00, height_r[CFG_W-1:1]});
  assign off_div = (off_s < 14'sd1) ? CFG_W'(1) : off_s[CFG_W-1:0];
  assign w_div   = (width_r == '0) ? CFG_W'(1) : width_r;
  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  always_comb begin
    if (cmd.div_src == DIV_SRC_DIST) begin
      div_dividend = DIV_W'(height_r) << (FRAC_BITS - 1);
      div_divisor  = off_div;
    end else begin
      div_dividend = prod_mag[DIV_W-1:0];
      div_divisor  = w_div;
    end
  end

  fcta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign status.div_done = div_done;

  // One shared multiplier: row distance times a direction term.
  logic signed [OP_W-1:0]   mul_op;
  logic signed [PROD_W:0]   mul_full;

  always_comb begin
    unique case (cmd.mul_src)
      MUL_STEP_X:  mul_op = {plane_x_r, 1'b0};
      MUL_STEP_Y:  mul_op = {plane_y_r, 1'b0};
      MUL_START_X: mul_op = OP_W'($signed({dir_x_r[VEC_W-1], dir_x_r})
                                  - $signed({plane_x_r[VEC_W-1], plane_x_r}));
      MUL_START_Y: mul_op = OP_W'($signed({dir_y_r[VEC_W-1], dir_y_r})
                                  - $signed({plane_y_r[VEC_W-1], plane_y_r}));
      default:     mul_op = '0;
    endcase
  end

  assign mul_full = $signed({1'b0, dist_r}) * mul_op;

  // Quotient gets the sign back (truncating division), then a floor shift.
  logic signed [PROD_W-1:0] q_signed, q_shift, p_shift;
  logic signed [ACC_W-1:0]  step_nxt, start_off;

  assign q_signed  = prod_r[PROD_W-1] ? -$signed({1'b0, div_quot})
                                      : $signed({1'b0, div_quot});
  assign q_shift   = q_signed >>> DIR_SHIFT;
  assign p_shift   = prod_r >>> DIR_SHIFT;
  assign step_nxt  = {{(ACC_W-PROD_W){q_shift[PROD_W-1]}}, q_shift};
  assign start_off = {{(ACC_W-PROD_W){p_shift[PROD_W-1]}}, p_shift};

  // Result word for the current column.
  logic [CFG_W-1:0] w_one, w_lim, last_col;
  out_item_t        out_nxt;

  assign w_one    = (width_r == '0) ? CFG_W'(1) : width_r;
  assign w_lim    = (w_one > CFG_W'(1 << ROW_W)) ? CFG_W'(1 << ROW_W) : w_one;
  assign last_col = w_lim - CFG_W'(1);

  always_comb begin
    out_nxt.pixel_column    = col_r;
    out_nxt.floor_row_out   = row_r;
    out_nxt.ceiling_row_out = height_r[ROW_W-1:0] - row_r - ROW_W'(1);
    out_nxt.floor_texel     = (fmode_r == MODE_TEXTURED)
        ? texel_index(acc_x_r[FRAC_BITS-1:0], acc_y_r[FRAC_BITS-1:0], flw_r, flh_r)
        : '0;
    out_nxt.ceiling_texel   = (cmode_r == MODE_TEXTURED)
        ? texel_index(acc_x_r[FRAC_BITS-1:0], acc_y_r[FRAC_BITS-1:0], clw_r, clh_r)
        : '0;
    out_nxt.floor_write     = !fmode_r[MODE_W-1];
    out_nxt.floor_solid     = (fmode_r == MODE_SOLID);
    out_nxt.ceiling_write   = !cmode_r[MODE_W-1];
    out_nxt.ceiling_solid   = (cmode_r == MODE_SOLID);
    out_nxt.row_last        = ({1'b0, col_r} == last_col);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
    end else begin
      if (cmd.row_load) begin
        row_r <= in_item.screen_row;
        col_r <= '0;
      end else if (cmd.pix_step) begin
        col_r <= col_r + ROW_W'(1);
      end
      if (cmd.step_x_load) step_x_r <= step_nxt;
      if (cmd.step_y_load) step_y_r <= step_nxt;
      if (cmd.acc_x_load) begin
        acc_x_r <= {{(ACC_W-POS_W){pos_x_r[POS_W-1]}}, pos_x_r} + start_off;
      end else if (cmd.pix_step) begin
        acc_x_r <= acc_x_r + step_x_r;
      end
      if (cmd.acc_y_load) begin
        acc_y_r <= {{(ACC_W-POS_W){pos_y_r[POS_W-1]}}, pos_y_r} + start_off;
      end else if (cmd.pix_step) begin
        acc_y_r <= acc_y_r + step_y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      pos_x_r   <= in_item.cam_pos_x;
      pos_y_r   <= in_item.cam_pos_y;
      dir_x_r   <= in_item.view_dir_x;
      dir_y_r   <= in_item.view_dir_y;
      plane_x_r <= in_item.view_plane_x;
      plane_y_r <= in_item.view_plane_y;
    end
    if (cmd.dist_load) dist_r <= div_quot[DIST_W-1:0];
    if (cmd.prod_load) prod_r <= mul_full[PROD_W-1:0];
    if (cmd.pix_step)  out_r  <= out_nxt;
  end

  assign out_item = out_r;

endmodule

// ----- design/fcta_ctrl.sv -----
// Controller: handshakes, result word valid flag and the row setup sequence.
// Depends on fcta_pkg; drives fcta_dp through ctrl_cmd_t.
module fcta_ctrl import fcta_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_cmd,
  input  logic         out_ready,
  input  ctrl_status_t status,
  output logic         in_ready,
  output logic         out_valid,
  output ctrl_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  // The result register frees up in the same cycle its word is taken.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (accept && in_cmd == CMD_ROW_START) state_nxt = ST_DIST_GO;
      ST_DIST_GO:   state_nxt = ST_DIST_WAIT;
      ST_DIST_WAIT: if (status.div_done) state_nxt = ST_SX_MUL;
      ST_SX_MUL:    state_nxt = ST_SX_GO;
      ST_SX_GO:     state_nxt = ST_SX_WAIT;
      ST_SX_WAIT:   if (status.div_done) state_nxt = ST_SY_MUL;
      ST_SY_MUL:    state_nxt = ST_SY_GO;
      ST_SY_GO:     state_nxt = ST_SY_WAIT;
      ST_SY_WAIT:   if (status.div_done) state_nxt = ST_X0_MUL;
      ST_X0_MUL:    state_nxt = ST_X0_LOAD;
      ST_X0_LOAD:   state_nxt = ST_Y0_MUL;
      ST_Y0_MUL:    state_nxt = ST_Y0_LOAD;
      ST_Y0_LOAD:   state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.div_src     = DIV_SRC_PROD;
    cmd.mul_src     = MUL_STEP_X;
    cmd.row_load    = accept && (in_cmd == CMD_ROW_START);
    cmd.pix_step    = accept && (in_cmd == CMD_PIXEL);
    unique case (state_r)
      ST_IDLE: ;
      ST_DIST_GO: begin
        cmd.div_src   = DIV_SRC_DIST;
        cmd.div_start = 1'b1;
      end
      ST_DIST_WAIT: cmd.dist_load = status.div_done;
      ST_SX_MUL: begin
        cmd.mul_src   = MUL_STEP_X;
        cmd.prod_load = 1'b1;
      end
      ST_SX_GO:   cmd.div_start   = 1'b1;
      ST_SX_WAIT: cmd.step_x_load = status.div_done;
      ST_SY_MUL: begin
        cmd.mul_src   = MUL_STEP_Y;
        cmd.prod_load = 1'b1;
      end
      ST_SY_GO:   cmd.div_start   = 1'b1;
      ST_SY_WAIT: cmd.step_y_load = status.div_done;
      ST_X0_MUL: begin
        cmd.mul_src   = MUL_START_X;
        cmd.prod_load = 1'b1;
      end
      ST_X0_LOAD: cmd.acc_x_load = 1'b1;
      ST_Y0_MUL: begin
        cmd.mul_src   = MUL_START_Y;
        cmd.prod_load = 1'b1;
      end
      ST_Y0_LOAD: cmd.acc_y_load = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pix_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/floor_ceiling_texel_addresser_top.sv -----
// Top level of the floor and ceiling texel addresser.
// Depends on fcta_pkg, fcta_ifs, fcta_ctrl and fcta_dp.
//
//   channel  direction  handshake        word
//   in_ch    sink       valid / ready    row start or pixel request
//   out_ch   source     valid / ready    one pixel's rows, texels and flags
//   cfg_*    write      cfg_we           register index and data
//
// A pixel word is taken every cycle while no row start is in setup and the
// result register is free or being read; its result appears on the next cycle.
// A row start runs the shared 44-step divider three times (row distance, then
// the x and y column steps), plus four multiplies.
// Reset is synchronous and active low. A stalled result holds the input off.
module floor_ceiling_texel_addresser_top import fcta_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fcta_in_if.sink              in_ch,
  fcta_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  in_item_t     in_item;
  out_item_t    out_item;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign in_item.cmd          = in_ch.cmd;
  assign in_item.screen_row   = in_ch.screen_row;
  assign in_item.cam_pos_x    = in_ch.cam_pos_x;
  assign in_item.cam_pos_y    = in_ch.cam_pos_y;
  assign in_item.view_dir_x   = in_ch.view_dir_x;
  assign in_item.view_dir_y   = in_ch.view_dir_y;
  assign in_item.view_plane_x = in_ch.view_plane_x;
  assign in_item.view_plane_y = in_ch.view_plane_y;

  fcta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .out_ready (out_ch.ready),
    .status    (status),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  fcta_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

  assign out_ch.pixel_column    = out_item.pixel_column;
  assign out_ch.floor_row_out   = out_item.floor_row_out;
  assign out_ch.ceiling_row_out = out_item.ceiling_row_out;
  assign out_ch.floor_texel     = out_item.floor_texel;
  assign out_ch.ceiling_texel   = out_item.ceiling_texel;
  assign out_ch.floor_write     = out_item.floor_write;
  assign out_ch.floor_solid     = out_item.floor_solid;
  assign out_ch.ceiling_write   = out_item.ceiling_write;
  assign out_ch.ceiling_solid   = out_item.ceiling_solid;
  assign out_ch.row_last        = out_item.row_last;

`ifndef ASSERT_OFF
  // A row start occupies the setup sequence, so the input closes right after it.
  a_row_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_ROW_START) |=> !in_ch.ready)
    else $error("input still open after a row start");

  // Every pixel word yields a result word on the next cycle.
  a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_PIXEL) |=> out_ch.valid)
    else $error("pixel word produced no result");

  // A result word only appears after a pixel word was taken.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready && in_ch.cmd == CMD_PIXEL))
    else $error("result word without a pixel word");

  // The divider never reports done during the multiply steps.
  a_div_done_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prod_load |-> !status.div_done)
    else $error("divider finished outside a wait step");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for floor_ceiling_texel_addresser_top: row starts and pixel words
// in, one predicted pixel word out per pixel, compared field by field.
// Depends on fcta_pkg, fcta_ifs and the design's top level.
module tb_top;
  import fcta_pkg::*;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
  localparam int ROW_LATENCY = 200;     // covers the time a row start keeps the block busy
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  fcta_in_if  in_ch ();
  fcta_out_if out_ch ();

  floor_ceiling_texel_addresser_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the registers and of the row state.
  logic [CFG_W-1:0]  m_width;
  logic [CFG_W-1:0]  m_height;
  logic [MODE_W-1:0] m_fmode;
  logic [MODE_W-1:0] m_cmode;
  logic [LOG2_W-1:0] m_flog_w, m_flog_h, m_clog_w, m_clog_h;
  logic [ACC_W-1:0]  wx_acc, wy_acc, wx_step, wy_step;
  logic [ROW_W-1:0]  row_reg, col_reg;

  in_item_t  pending_words[$];
  out_item_t pixel_expect[$];

  bit gaps_on;
  bit in_taken;
  int send_gap;
  int stall_left;
  int n_fail;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [TEX_W-1:0] tex_index(logic [FRAC_BITS-1:0] fx,
                                                 logic [FRAC_BITS-1:0] fy,
                                                 logic [LOG2_W-1:0] lw_raw,
                                                 logic [LOG2_W-1:0] lh_raw);
    int lw;
    int lh;
    logic [31:0] tx;
    logic [31:0] ty;
    lw = (lw_raw > MAX_TEX_LOG2) ? MAX_TEX_LOG2 : int'(lw_raw);
    lh = (lh_raw > MAX_TEX_LOG2) ? MAX_TEX_LOG2 : int'(lh_raw);
    if (lw > FRAC_BITS) lw = FRAC_BITS;
    if (lh > FRAC_BITS) lh = FRAC_BITS;
    tx = 32'(fx) >> (FRAC_BITS - lw);
    ty = 32'(fy) >> (FRAC_BITS - lh);
    return TEX_W'((ty << lw) | tx);
  endfunction

  // Row distance, column step and world point under column zero.
  task automatic load_row(input in_item_t it);
    longint h, w, off, rdist, dx, dy, px, py, sx, sy, x0, y0;
    h = longint'(m_height);
    if (m_width == 0) w = 1;
    else w = longint'(m_width);
    off = longint'(it.screen_row) - h / 2;
    if (off < 1) off = 1;
    rdist = (h <<< (FRAC_BITS - 1)) / off;
    dx = longint'($signed(it.view_dir_x));
    dy = longint'($signed(it.view_dir_y));
    px = longint'($signed(it.view_plane_x));
    py = longint'($signed(it.view_plane_y));
    sx = ((rdist * (2 * px)) / w) >>> DIR_SHIFT;
    sy = ((rdist * (2 * py)) / w) >>> DIR_SHIFT;
    x0 = longint'($signed(it.cam_pos_x)) + ((rdist * (dx - px)) >>> DIR_SHIFT);
    y0 = longint'($signed(it.cam_pos_y)) + ((rdist * (dy - py)) >>> DIR_SHIFT);
    wx_step = sx[ACC_W-1:0];
    wy_step = sy[ACC_W-1:0];
    wx_acc  = x0[ACC_W-1:0];
    wy_acc  = y0[ACC_W-1:0];
    row_reg = it.screen_row;
    col_reg = '0;
  endtask

  task automatic next_pixel(output out_item_t r);
    int wl;
    if (m_width == 0) wl = 1;
    else if (m_width > 4096) wl = 4096;
    else wl = int'(m_width);
    r.pixel_column    = col_reg;
    r.floor_row_out   = row_reg;
    r.ceiling_row_out = ROW_W'(int'(m_height) - int'(row_reg) - 1);
    r.floor_texel   = (m_fmode == MODE_TEXTURED) ?
                      tex_index(wx_acc[FRAC_BITS-1:0], wy_acc[FRAC_BITS-1:0],
                                m_flog_w, m_flog_h) : '0;
    r.ceiling_texel = (m_cmode == MODE_TEXTURED) ?
                      tex_index(wx_acc[FRAC_BITS-1:0], wy_acc[FRAC_BITS-1:0],
                                m_clog_w, m_clog_h) : '0;
    r.floor_write   = (m_fmode == MODE_TEXTURED) || (m_fmode == MODE_SOLID);
    r.floor_solid   = (m_fmode == MODE_SOLID);
    r.ceiling_write = (m_cmode == MODE_TEXTURED) || (m_cmode == MODE_SOLID);
    r.ceiling_solid = (m_cmode == MODE_SOLID);
    r.row_last      = (int'(col_reg) == wl - 1);
    wx_acc  = wx_acc + wx_step;
    wy_acc  = wy_acc + wy_step;
    col_reg = col_reg + 1'b1;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // Watch both channels and the register port at each rising edge.
  always @(posedge clk) begin
    in_item_t  w;
    out_item_t got;
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  m_width  = cfg_wdata;
        CFG_SCREEN_HEIGHT: m_height = cfg_wdata;
        CFG_FLOOR_MODE:    m_fmode  = cfg_wdata[MODE_W-1:0];
        CFG_CEILING_MODE:  m_cmode  = cfg_wdata[MODE_W-1:0];
        CFG_FLOOR_LOG2_W:  m_flog_w = cfg_wdata[LOG2_W-1:0];
        CFG_FLOOR_LOG2_H:  m_flog_h = cfg_wdata[LOG2_W-1:0];
        CFG_CEIL_LOG2_W:   m_clog_w = cfg_wdata[LOG2_W-1:0];
        CFG_CEIL_LOG2_H:   m_clog_h = cfg_wdata[LOG2_W-1:0];
        default: ;
      endcase
    end
    if (in_taken) begin
      w.cmd          = in_ch.cmd;
      w.screen_row   = in_ch.screen_row;
      w.cam_pos_x    = in_ch.cam_pos_x;
      w.cam_pos_y    = in_ch.cam_pos_y;
      w.view_dir_x   = in_ch.view_dir_x;
      w.view_dir_y   = in_ch.view_dir_y;
      w.view_plane_x = in_ch.view_plane_x;
      w.view_plane_y = in_ch.view_plane_y;
      if (w.cmd == CMD_ROW_START) begin
        load_row(w);
      end else begin
        next_pixel(want);
        pixel_expect.push_back(want);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pixel_column    = out_ch.pixel_column;
      got.floor_row_out   = out_ch.floor_row_out;
      got.ceiling_row_out = out_ch.ceiling_row_out;
      got.floor_texel     = out_ch.floor_texel;
      got.ceiling_texel   = out_ch.ceiling_texel;
      got.floor_write     = out_ch.floor_write;
      got.floor_solid     = out_ch.floor_solid;
      got.ceiling_write   = out_ch.ceiling_write;
      got.ceiling_solid   = out_ch.ceiling_solid;
      got.row_last        = out_ch.row_last;
      if (pixel_expect.size() == 0) begin
        $error("result word with no pixel pending: column %0d", got.pixel_column);
        n_fail++;
      end else begin
        want = pixel_expect.pop_front();
        check_field("pixel_column", want.pixel_column, got.pixel_column);
        check_field("floor_row_out", want.floor_row_out, got.floor_row_out);
        check_field("ceiling_row_out", want.ceiling_row_out, got.ceiling_row_out);
        check_field("floor_texel", want.floor_texel, got.floor_texel);
        check_field("ceiling_texel", want.ceiling_texel, got.ceiling_texel);
        check_field("floor_write", want.floor_write, got.floor_write);
        check_field("floor_solid", want.floor_solid, got.floor_solid);
        check_field("ceiling_write", want.ceiling_write, got.ceiling_write);
        check_field("ceiling_solid", want.ceiling_solid, got.ceiling_solid);
        check_field("row_last", want.row_last, got.row_last);
      end
    end
  end

  // Sender: a word stays up until taken; between words it may go idle for a burst.
  always @(negedge clk) begin
    logic show;
    if (in_taken) pending_words.pop_front();
    show = in_ch.valid && !in_taken;
    if (!show) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 4) - 1;
      end else begin
        show = rst_n && (pending_words.size() != 0);
      end
    end
    in_ch.valid <= show;
    if (show) begin
      in_ch.cmd          <= pending_words[0].cmd;
      in_ch.screen_row   <= pending_words[0].screen_row;
      in_ch.cam_pos_x    <= pending_words[0].cam_pos_x;
      in_ch.cam_pos_y    <= pending_words[0].cam_pos_y;
      in_ch.view_dir_x   <= pending_words[0].view_dir_x;
      in_ch.view_dir_y   <= pending_words[0].view_dir_y;
      in_ch.view_plane_x <= pending_words[0].view_plane_x;
      in_ch.view_plane_y <= pending_words[0].view_plane_y;
    end
  end

  // Receiver: stalls in random bursts while gaps are on.
  always @(negedge clk) begin
    logic rdy;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ch.ready <= rdy && rst_n;
  end

  function automatic logic [VEC_W-1:0] pick_vec();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'h0000;
      default: return VEC_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return POS_W'($signed(VEC_W'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_word(logic cmd, int row);
    in_item_t w;
    w.cmd          = cmd;
    w.screen_row   = ROW_W'(row);
    w.cam_pos_x    = pick_pos();
    w.cam_pos_y    = pick_pos();
    w.view_dir_x   = pick_vec();
    w.view_dir_y   = pick_vec();
    w.view_plane_x = pick_vec();
    w.view_plane_y = pick_vec();
    return w;
  endfunction

  task automatic add_pixels(int n);
    repeat (n) pending_words.push_back(make_word(CMD_PIXEL, $urandom_range(0, 4095)));
  endtask

  task automatic add_row(int row, int n);
    pending_words.push_back(make_word(CMD_ROW_START, row));
    add_pixels(n);
  endtask

  task automatic push_start(int row, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                            logic [VEC_W-1:0] dx, logic [VEC_W-1:0] dy,
                            logic [VEC_W-1:0] plx, logic [VEC_W-1:0] ply);
    in_item_t w;
    w = make_word(CMD_ROW_START, row);
    w.cam_pos_x    = px;
    w.cam_pos_y    = py;
    w.view_dir_x   = dx;
    w.view_dir_y   = dy;
    w.view_plane_x = plx;
    w.view_plane_y = ply;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_W'(val);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_regs(int wdt, int hgt, int fm, int cm, int flw, int flh,
                          int clw, int clh);
    write_reg(CFG_SCREEN_WIDTH, wdt);
    write_reg(CFG_SCREEN_HEIGHT, hgt);
    write_reg(CFG_FLOOR_MODE, fm);
    write_reg(CFG_CEILING_MODE, cm);
    write_reg(CFG_FLOOR_LOG2_W, flw);
    write_reg(CFG_FLOOR_LOG2_H, flh);
    write_reg(CFG_CEIL_LOG2_W, clw);
    write_reg(CFG_CEIL_LOG2_H, clh);
  endtask

  // Wait until every word is sent and every pixel has come back, then let a
  // possible row start finish, since it produces nothing to wait on.
  task automatic settle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_ch.valid || pixel_expect.size() != 0);
    repeat (ROW_LATENCY) @(posedge clk);
  endtask

  function automatic int pick_log2();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, MAX_TEX_LOG2);
  endfunction

  task automatic random_phase(int n_words, bit pause_midway);
    int wdt, hgt, fm, cm, wl, lo, hi, sent, n, kind;
    bit paused;
    case ($urandom_range(0, 7))
      0: wdt = 0;
      1: wdt = 4096;
      2: wdt = 8191;
      default: wdt = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0: hgt = 0;
      1: hgt = 1;
      2: hgt = 4096;
      3: hgt = 8191;
      default: hgt = $urandom_range(2, 600);
    endcase
    fm = $urandom_range(0, 5);
    if (fm > 3) fm = MODE_TEXTURED;
    cm = $urandom_range(0, 5);
    if (cm > 3) cm = MODE_TEXTURED;
    set_regs(wdt, hgt, fm, cm, pick_log2(), pick_log2(), pick_log2(), pick_log2());
    wl = (wdt == 0) ? 1 : wdt;
    lo = hgt / 2 + 1;
    hi = (hgt - 1 > 4095) ? 4095 : hgt - 1;
    sent = 0;
    paused = 1'b0;
    while (sent < n_words) begin
      if (pause_midway && !paused && sent >= n_words / 2) begin
        paused = 1'b1;
        settle();
      end
      kind = $urandom_range(0, 19);
      if (kind < 17) begin
        // A row, below the horizon where it fits, whole up to width 48, at times overrun.
        n = (wl > 48) ? $urandom_range(1, 48) : wl;
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
        add_row((lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 4095), n);
        sent += n + 1;
      end else if (kind < 19) begin
        n = $urandom_range(0, 3);
        add_row($urandom_range(0, 4095), n);
        sent += n + 1;
      end else begin
        add_pixels(2);
        sent += 2;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SCREEN_WIDTH;
    cfg_wdata  = '0;
    gaps_on    = 1'b1;
    in_taken   = 1'b0;
    send_gap   = 0;
    stall_left = 0;
    n_fail     = 0;
    cycles     = 0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_PIXEL;
    in_ch.screen_row   = '0;
    in_ch.cam_pos_x    = '0;
    in_ch.cam_pos_y    = '0;
    in_ch.view_dir_x   = '0;
    in_ch.view_dir_y   = '0;
    in_ch.view_plane_x = '0;
    in_ch.view_plane_y = '0;
    out_ch.ready       = 1'b0;
    m_width  = 13'd640;
    m_height = 13'd480;
    m_fmode  = MODE_TEXTURED;
    m_cmode  = MODE_TEXTURED;
    m_flog_w = 4'd6;
    m_flog_h = 4'd6;
    m_clog_w = 4'd6;
    m_clog_h = 4'd6;
    wx_acc   = '0;
    wy_acc   = '0;
    wx_step  = '0;
    wy_step  = '0;
    row_reg  = '0;
    col_reg  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: pixels before any row start, then rows at the horizon,
    // above it, past the bottom and just below it, with extreme camera words.
    add_pixels(2);
    push_start(240, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_pixels(2);
    push_start(0, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_pixels(2);
    push_start(4095, 32'h0000_0000, 32'h0000_0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000);
    add_pixels(2);
    push_start(241, 32'hFFFF_8000, 32'h0001_8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    add_pixels(3);
    settle();

    // Zero width, tiny height so the ceiling row wraps, clamped texture sizes.
    set_regs(0, 1, MODE_SOLID, MODE_RSVD, 15, 0, MAX_TEX_LOG2, 9);
    add_row(5, 3);
    settle();

    // Tallest screen; pixels run one column past the end of a three-wide row.
    set_regs(3, 8191, MODE_OFF, MODE_SOLID, 8, 8, 8, 8);
    add_row(4095, 4);
    settle();

    for (int p = 0; p < 8; p++) begin
      gaps_on = (p < 6);
      random_phase(110, p == 2);
      settle();
    end

    // Widths past 4096 put the last column at 4095, so a short row never ends.
    set_regs(8191, 8191, MODE_TEXTURED, MODE_TEXTURED, MAX_TEX_LOG2, MAX_TEX_LOG2,
             MAX_TEX_LOG2, MAX_TEX_LOG2);
    add_row(4095, 40);
    settle();

    if (n_fail == 0 && pixel_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
